// ===== rtl/gpr_pkg.sv =====
package gpr_pkg;

  localparam int VERTEX_W = 6;
  localparam int COUNT_W  = 7;
  localparam int ROW_W    = 64;
  localparam int CFG_W    = 7;

  typedef enum logic [1:0] {
    REQ_ADD_EDGE = 2'd0,
    REQ_QUERY    = 2'd1,
    REQ_CLEAR    = 2'd2
  } req_type_t;

  typedef enum logic {
    CFG_VERTEX_COUNT = 1'b0,
    CFG_DEPTH_LIMIT  = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD1,
    ST_ADD_WR1,
    ST_ADD_RD2,
    ST_ADD_WR2,
    ST_SCAN,
    ST_LEVEL,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/graph_power_reachability.sv =====
// Depth-limited reachability over an adjacency bit matrix held in a one-read, one-write
// memory of MAX_VERTICES rows. An add-edge beat does a read-modify-write of one row
// (directed) or two rows (undirected); a clear beat is handled without leaving ST_IDLE.
// A query searches L levels, where L is at most the depth limit (0 counts as 1, values
// above 64 as 64) and fewer once no new vertex is found; every level scans all live
// rows through the single memory read port. One beat is worked on at a time; a finished
// result sits in an output register while the next beat is taken.
module graph_power_reachability #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [gpr_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [gpr_pkg::VERTEX_W-1:0] in_edge_from,
  input  logic [gpr_pkg::VERTEX_W-1:0] in_edge_to,
  input  logic                        in_edge_directed,
  input  logic [gpr_pkg::VERTEX_W-1:0] in_source_vertex,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gpr_pkg::ROW_W-1:0]   out_reach_mask,
  output logic                        out_result_directed,
  output logic [gpr_pkg::VERTEX_W-1:0] out_source_echo
);
  import gpr_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   vertex_count_r, depth_limit_r;
  logic                 any_edge_r, any_edge_nxt;
  logic                 undir_r, undir_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]     out_reach_r, out_reach_nxt;
  logic                 out_dir_r, out_dir_nxt;
  logic [VERTEX_W-1:0]  out_src_r, out_src_nxt;

  logic [VERTEX_W-1:0]  from_r, from_nxt;
  logic [VERTEX_W-1:0]  to_r, to_nxt;
  logic                 dir_r, dir_nxt;
  logic [VERTEX_W-1:0]  src_r, src_nxt;
  logic                 src_ok_r, src_ok_nxt;
  logic [ROW_W-1:0]     seen_r, seen_nxt;
  logic [ROW_W-1:0]     frontier_r, frontier_nxt;
  logic [ROW_W-1:0]     next_r, next_nxt;
  logic                 pend_r, pend_nxt;
  logic [COUNT_W-1:0]   scan_r, scan_nxt;
  logic [COUNT_W-1:0]   level_r, level_nxt;

  logic [ROW_W-1:0]        adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_r;
  logic [ROW_W-1:0]        rd_data_r;
  logic                    rd_ok_r;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [ROW_W-1:0]        mem_wdata;
  logic                    clear_graph;

  logic [COUNT_W-1:0]   n_live, k_eff;
  logic [ROW_W-1:0]     valid_mask, above_src, row_eff, level_new, reach;
  logic                 in_accept, directed;

  assign n_live = (vertex_count_r > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                           : vertex_count_r;
  assign k_eff  = (depth_limit_r == '0) ? COUNT_W'(1)
                : (depth_limit_r > COUNT_W'(ROW_W)) ? COUNT_W'(ROW_W) : depth_limit_r;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      valid_mask[i] = (COUNT_W'(i) < n_live);
      above_src[i]  = (COUNT_W'(i) > {1'b0, src_r});
    end
  end

  assign row_eff   = rd_ok_r ? rd_data_r : '0;
  assign level_new = (next_r | (pend_r ? row_eff : '0)) & valid_mask & ~seen_r;
  assign directed  = any_edge_r && !undir_r;
  assign reach     = src_ok_r ? (seen_r & valid_mask & ~(ROW_W'(1) << src_r)
                                 & (directed ? '1 : above_src))
                              : '0;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    any_edge_nxt  = any_edge_r;
    undir_nxt     = undir_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_reach_nxt = out_reach_r;
    out_dir_nxt   = out_dir_r;
    out_src_nxt   = out_src_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    dir_nxt       = dir_r;
    src_nxt       = src_r;
    src_ok_nxt    = src_ok_r;
    seen_nxt      = seen_r;
    frontier_nxt  = frontier_r;
    next_nxt      = next_r;
    pend_nxt      = pend_r;
    scan_nxt      = scan_r;
    level_nxt     = level_r;
    mem_we        = 1'b0;
    mem_waddr     = from_r[AW-1:0];
    mem_wdata     = row_eff;
    mem_raddr     = scan_r[AW-1:0];
    clear_graph   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_req_type)
            REQ_ADD_EDGE: begin
              if ({1'b0, in_edge_from} < n_live && {1'b0, in_edge_to} < n_live) begin
                from_nxt     = in_edge_from;
                to_nxt       = in_edge_to;
                dir_nxt      = in_edge_directed;
                any_edge_nxt = 1'b1;
                undir_nxt    = undir_r || !in_edge_directed;
                state_nxt    = ST_ADD_RD1;
              end
            end
            REQ_QUERY: begin
              src_nxt      = in_source_vertex;
              src_ok_nxt   = ({1'b0, in_source_vertex} < n_live);
              seen_nxt     = ROW_W'(1) << in_source_vertex;
              frontier_nxt = ROW_W'(1) << in_source_vertex;
              next_nxt     = '0;
              pend_nxt     = 1'b0;
              scan_nxt     = '0;
              level_nxt    = '0;
              state_nxt    = ({1'b0, in_source_vertex} < n_live) ? ST_SCAN : ST_DONE;
            end
            REQ_CLEAR: begin
              clear_graph  = 1'b1;
              any_edge_nxt = 1'b0;
              undir_nxt    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_RD1: begin
        mem_raddr = from_r[AW-1:0];
        state_nxt = ST_ADD_WR1;
      end
      ST_ADD_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = from_r[AW-1:0];
        mem_wdata = row_eff | (ROW_W'(1) << to_r);
        state_nxt = dir_r ? ST_IDLE : ST_ADD_RD2;
      end
      ST_ADD_RD2: begin
        mem_raddr = to_r[AW-1:0];
        state_nxt = ST_ADD_WR2;
      end
      ST_ADD_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = to_r[AW-1:0];
        mem_wdata = row_eff | (ROW_W'(1) << from_r);
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        pend_nxt = frontier_r[scan_r[VERTEX_W-1:0]];
        next_nxt = next_r | (pend_r ? row_eff : '0);
        scan_nxt = scan_r + COUNT_W'(1);
        if (scan_r + COUNT_W'(1) >= n_live) begin
          state_nxt = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        seen_nxt     = seen_r | level_new;
        frontier_nxt = level_new;
        level_nxt    = level_r + COUNT_W'(1);
        next_nxt     = '0;
        pend_nxt     = 1'b0;
        scan_nxt     = '0;
        if (level_r + COUNT_W'(1) >= k_eff || level_new == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_reach_nxt = reach;
          out_dir_nxt   = directed;
          out_src_nxt   = src_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      vertex_count_r <= COUNT_W'(64);
      depth_limit_r  <= COUNT_W'(1);
      any_edge_r     <= 1'b0;
      undir_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      any_edge_r  <= any_edge_nxt;
      undir_r     <= undir_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_VERTEX_COUNT: vertex_count_r <= cfg_wdata;
          CFG_DEPTH_LIMIT:  depth_limit_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_reach_r <= out_reach_nxt;
    out_dir_r   <= out_dir_nxt;
    out_src_r   <= out_src_nxt;
    from_r      <= from_nxt;
    to_r        <= to_nxt;
    dir_r       <= dir_nxt;
    src_r       <= src_nxt;
    src_ok_r    <= src_ok_nxt;
    seen_r      <= seen_nxt;
    frontier_r  <= frontier_nxt;
    next_r      <= next_nxt;
    pend_r      <= pend_nxt;
    scan_r      <= scan_nxt;
    level_r     <= level_nxt;
  end

  // A row whose valid bit is clear reads as empty, so reset and clear only clear the valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (clear_graph) begin
      row_vld_r <= '0;
    end else if (mem_we) begin
      row_vld_r[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      adj_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= adj_mem[mem_raddr];
    rd_ok_r   <= row_vld_r[mem_raddr];
  end

  assign out_valid           = out_valid_r;
  assign out_reach_mask      = out_reach_r;
  assign out_result_directed = out_dir_r;
  assign out_source_echo     = out_src_r;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_r < n_live))
    else $error("Row scan ran past the live vertex count.");

  a_frontier_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_LEVEL) |-> ((frontier_r & ~seen_r) == '0))
    else $error("Frontier holds a vertex that is not marked as seen.");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_ADD_WR1 || state_r == ST_ADD_WR2))
    else $error("Adjacency memory written outside an add-edge update.");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && state_r == ST_IDLE))
    else $error("Finished query did not reach the output register.");

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_req_type == REQ_QUERY && {1'b0, in_source_vertex} < n_live) |=>
      (state_r == ST_SCAN))
    else $error("Query with a live source did not start a row scan.");

endmodule

// ===== tb/sv/graph_power_reachability_test.sv =====
`timescale 1ns / 100ps

module graph_power_reachability_test;
  import gpr_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned ITEM_TARGET = 1150;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic [ROW_W-1:0]    reach;
    logic                directed;
    logic [VERTEX_W-1:0] source;
  } reach_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  cfg_index_t          cfg_index = CFG_VERTEX_COUNT;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_req_type = '0;
  logic [VERTEX_W-1:0] in_edge_from = '0;
  logic [VERTEX_W-1:0] in_edge_to = '0;
  logic                in_edge_directed = 1'b0;
  logic [VERTEX_W-1:0] in_source_vertex = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ROW_W-1:0]    out_reach_mask;
  logic                out_result_directed;
  logic [VERTEX_W-1:0] out_source_echo;

  logic [ROW_W-1:0] graph_rows [64] = '{default: '0};
  logic             edge_seen = 1'b0;
  logic             undirected_edge_seen = 1'b0;
  logic [CFG_W-1:0] vertex_count_cfg = 7'd64;
  logic [CFG_W-1:0] depth_limit_cfg = 7'd1;
  reach_row_t       pending_rows [$];

  int unsigned items_sent = 0;
  int unsigned effective_beats = 0;
  int unsigned queries_sent = 0;
  int unsigned rows_checked = 0;
  int unsigned settings_written = 0;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 1;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_run = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned quiet_cycles = 0;

  graph_power_reachability dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_edge_from        (in_edge_from),
    .in_edge_to          (in_edge_to),
    .in_edge_directed    (in_edge_directed),
    .in_source_vertex    (in_source_vertex),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_reach_mask      (out_reach_mask),
    .out_result_directed (out_result_directed),
    .out_source_echo     (out_source_echo)
  );

  always #5 clk = ~clk;

  function automatic int unsigned live_vertices();
    return (vertex_count_cfg > 64) ? 64 : vertex_count_cfg;
  endfunction

  function automatic reach_row_t predict_reach_row(input logic [VERTEX_W-1:0] src);
    int unsigned live_n;
    int unsigned levels;
    int unsigned lvl;
    int unsigned v;
    logic [ROW_W-1:0] live_set;
    logic [ROW_W-1:0] seen;
    logic [ROW_W-1:0] frontier;
    logic [ROW_W-1:0] next_set;
    logic [ROW_W-1:0] self_bit;
    reach_row_t row;
    live_n = live_vertices();
    live_set = (live_n >= 64) ? {ROW_W{1'b1}} : ((64'd1 << live_n) - 64'd1);
    if (depth_limit_cfg == 0) begin
      levels = 1;
    end else if (depth_limit_cfg > 64) begin
      levels = 64;
    end else begin
      levels = depth_limit_cfg;
    end
    row.directed = edge_seen && !undirected_edge_seen;
    row.source = src;
    row.reach = '0;
    if (src < live_n) begin
      self_bit = 64'd1 << src;
      seen = self_bit;
      frontier = self_bit;
      for (lvl = 0; lvl < levels && frontier != 0; lvl++) begin
        next_set = '0;
        for (v = 0; v < live_n; v++) begin
          if (frontier[v]) begin
            next_set |= graph_rows[v];
          end
        end
        next_set &= live_set & ~seen;
        seen |= next_set;
        frontier = next_set;
      end
      row.reach = seen & live_set & ~self_bit;
      if (!row.directed) begin
        row.reach &= ~((64'd2 << src) - 64'd1);
      end
    end
    return row;
  endfunction

  task automatic absorb_beat(input logic [1:0] kind, input logic [VERTEX_W-1:0] from_v,
                             input logic [VERTEX_W-1:0] to_v, input logic dir,
                             input logic [VERTEX_W-1:0] src);
    int unsigned live_n;
    live_n = live_vertices();
    case (kind)
      REQ_CLEAR: begin
        graph_rows = '{default: '0};
        edge_seen = 1'b0;
        undirected_edge_seen = 1'b0;
        effective_beats++;
      end
      REQ_ADD_EDGE: begin
        if (from_v < live_n && to_v < live_n) begin
          graph_rows[from_v][to_v] = 1'b1;
          if (!dir) begin
            graph_rows[to_v][from_v] = 1'b1;
            undirected_edge_seen = 1'b1;
          end
          edge_seen = 1'b1;
          effective_beats++;
        end
      end
      REQ_QUERY: begin
        pending_rows.push_back(predict_reach_row(src));
        queries_sent++;
        effective_beats++;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_beat(input logic [1:0] kind, input logic [VERTEX_W-1:0] from_v,
                           input logic [VERTEX_W-1:0] to_v, input logic dir,
                           input logic [VERTEX_W-1:0] src);
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_edge_from <= from_v;
    in_edge_to <= to_v;
    in_edge_directed <= dir;
    in_source_vertex <= src;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
    absorb_beat(kind, from_v, to_v, dir, src);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t index, input logic [CFG_W-1:0] value);
    drain_and_idle();
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == CFG_VERTEX_COUNT) begin
      vertex_count_cfg = value;
    end else begin
      depth_limit_cfg = value;
    end
    settings_written++;
  endtask

  task automatic test_empty_graph_after_reset();
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd0);
    send_beat(REQ_QUERY, 6'd63, 6'd63, 1'b1, 6'd63);
  endtask

  task automatic test_edge_kinds();
    send_beat(REQ_ADD_EDGE, 6'd0, 6'd63, 1'b1, 6'd0);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd0);
    send_beat(REQ_ADD_EDGE, 6'd5, 6'd5, 1'b1, 6'd0);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd5);
    send_beat(REQ_ADD_EDGE, 6'd63, 6'd1, 1'b0, 6'd0);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd63);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd1);
    send_beat(REQ_UNUSED, 6'd63, 6'd63, 1'b1, 6'd63);
    send_beat(REQ_CLEAR, 6'd0, 6'd0, 1'b0, 6'd0);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd0);
  endtask

  task automatic test_register_extremes();
    write_register(CFG_DEPTH_LIMIT, 7'd0);
    write_register(CFG_VERTEX_COUNT, 7'd127);
    send_beat(REQ_ADD_EDGE, 6'd0, 6'd1, 1'b1, 6'd0);
    send_beat(REQ_ADD_EDGE, 6'd1, 6'd2, 1'b1, 6'd0);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd0);
    write_register(CFG_DEPTH_LIMIT, 7'd127);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd0);
    write_register(CFG_VERTEX_COUNT, 7'd2);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd0);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd5);
    send_beat(REQ_ADD_EDGE, 6'd1, 6'd3, 1'b1, 6'd0);
    send_beat(REQ_ADD_EDGE, 6'd3, 6'd0, 1'b0, 6'd0);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd1);
    write_register(CFG_VERTEX_COUNT, 7'd0);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd0);
    write_register(CFG_VERTEX_COUNT, 7'd64);
    write_register(CFG_DEPTH_LIMIT, 7'd64);
    send_beat(REQ_QUERY, 6'd0, 6'd0, 1'b0, 6'd0);
  endtask

  task automatic test_output_hold_off();
    write_register(CFG_VERTEX_COUNT, 7'd8);
    write_register(CFG_DEPTH_LIMIT, 7'd3);
    send_beat(REQ_CLEAR, 6'd0, 6'd0, 1'b0, 6'd0);
    repeat (6) begin
      send_beat(REQ_ADD_EDGE, VERTEX_W'($urandom_range(0, 7)), VERTEX_W'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)), VERTEX_W'($urandom));
    end
    hold_requests <= hold_requests + 1;
    repeat (30) begin
      send_beat(REQ_QUERY, VERTEX_W'($urandom), VERTEX_W'($urandom), 1'($urandom),
                VERTEX_W'($urandom_range(0, 7)));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned roll;
    int unsigned live_n;
    int unsigned phase_len;
    logic [CFG_W-1:0] count_value;
    logic [CFG_W-1:0] depth_value;
    logic phase_directed;
    logic [VERTEX_W-1:0] from_v;
    logic [VERTEX_W-1:0] to_v;
    logic [VERTEX_W-1:0] src;
    logic dir;
    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
        count_value = CFG_W'($urandom_range(2, 16));
      end else if (roll < 8) begin
        count_value = CFG_W'($urandom_range(17, 63));
      end else if (roll == 8) begin
        count_value = CFG_W'($urandom_range(64, 127));
      end else begin
        count_value = CFG_W'($urandom_range(0, 1));
      end
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        depth_value = CFG_W'($urandom_range(0, 6));
      end else if (roll == 7) begin
        depth_value = CFG_W'($urandom_range(7, 63));
      end else if (roll == 8) begin
        depth_value = 7'd64;
      end else begin
        depth_value = CFG_W'($urandom_range(65, 127));
      end
      write_register(CFG_VERTEX_COUNT, count_value);
      write_register(CFG_DEPTH_LIMIT, depth_value);
      live_n = live_vertices();
      phase_directed = ($urandom_range(0, 2) == 0);
      if (phase_directed || $urandom_range(0, 2) == 0) begin
        send_beat(REQ_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom), 1'($urandom),
                  VERTEX_W'($urandom));
      end
      phase_len = $urandom_range(16, 56);
      repeat (phase_len) begin
        from_v = VERTEX_W'($urandom);
        to_v = VERTEX_W'($urandom);
        src = VERTEX_W'($urandom);
        dir = phase_directed ? 1'b1 : 1'(($urandom_range(0, 1)));
        roll = $urandom_range(0, 99);
        if (roll < 45 && live_n != 0) begin
          send_beat(REQ_ADD_EDGE, VERTEX_W'($urandom_range(0, live_n - 1)),
                    VERTEX_W'($urandom_range(0, live_n - 1)), dir, src);
        end else if (roll < 85) begin
          if (live_n != 0 && $urandom_range(0, 7) != 0) begin
            src = VERTEX_W'($urandom_range(0, live_n - 1));
          end
          send_beat(REQ_QUERY, from_v, to_v, 1'($urandom), src);
        end else if (roll < 93) begin
          send_beat(REQ_ADD_EDGE, from_v, to_v, dir, src);
        end else if (roll < 96) begin
          send_beat(REQ_CLEAR, from_v, to_v, 1'($urandom), src);
        end else begin
          send_beat(REQ_UNUSED, from_v, to_v, 1'($urandom), src);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_run == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          stall_run = $urandom_range(8, 64);
        end
        stall_run--;
        case (stall_mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (stall_run % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    reach_row_t expected_row;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected result beat: mask %h directed %b source %0d",
                   out_reach_mask, out_result_directed, out_source_echo);
        end
      end else begin
        expected_row = pending_rows.pop_front();
        rows_checked++;
        if (out_reach_mask !== expected_row.reach ||
            out_result_directed !== expected_row.directed ||
            out_source_echo !== expected_row.source) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Row mismatch: expected mask %h directed %b source %0d, got %h %b %0d",
                     expected_row.reach, expected_row.directed, expected_row.source,
                     out_reach_mask, out_result_directed, out_source_echo);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out after %0d cycles without a beat.", quiet_cycles);
      $display("graph_power_reachability_test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_graph_after_reset();
    test_edge_kinds();
    test_register_extremes();
    test_output_hold_off();
    test_random_traffic();
    drain_and_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d input beats, %0d effective (%0d queries), over %0d register writes.",
             items_sent, effective_beats, queries_sent, settings_written);
    $display("Checked %0d result rows, %0d mismatches.", rows_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("graph_power_reachability_test passed");
    end else begin
      $display("graph_power_reachability_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gpr_pkg.sv
rtl/graph_power_reachability.sv
tb/sv/graph_power_reachability_test.sv
